### rtl/key_matrix_debounce_scanner_unit_defines.svh
// ---------------------------------------------------------------------------
// key matrix debounce scanner: assertion macros
// shared clocking and reset gating for concurrent checks
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_UNIT_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define KMDS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kmds_pkg.sv
// ---------------------------------------------------------------------------
// kmds_pkg
// shared widths, constants and row state types of the key matrix scanner
// ---------------------------------------------------------------------------
package kmds_pkg;

  localparam int KeyRows = 8;
  localparam int RowW    = 3;
  localparam int ColW    = 8;
  localparam int CntW    = 4;
  localparam int CodeW   = 7;
  localparam int ColIdxW = 3;

  localparam logic [CntW-1:0] DebounceReset = 4'd3;

  // per-row state word held in the state memory
  typedef struct packed {
    logic [ColW-1:0] stable;
    logic [ColW-1:0] cand;
    logic [CntW-1:0] count;
  } row_state_t;

  // result of one row update
  typedef struct packed {
    logic             event_valid;
    logic [CodeW-1:0] key_code;
    logic [ColW-1:0]  stable_row;
  } row_result_t;

endpackage

### rtl/kmds_if.sv
// ---------------------------------------------------------------------------
// kmds interfaces
// valid/ready channels for scanned rows and key events
// ---------------------------------------------------------------------------
interface kmds_in_if;
  logic                       valid;
  logic                       ready;
  logic [kmds_pkg::RowW-1:0]  row_index;
  logic [kmds_pkg::ColW-1:0]  column_bits;
  logic                       receiver_ready;

  modport source (output valid, row_index, column_bits, receiver_ready, input ready);
  modport sink   (input valid, row_index, column_bits, receiver_ready, output ready);
endinterface

interface kmds_out_if;
  logic                       valid;
  logic                       ready;
  logic                       event_valid;
  logic [kmds_pkg::CodeW-1:0] key_code;
  logic [kmds_pkg::ColW-1:0]  stable_row;

  modport source (output valid, event_valid, key_code, stable_row, input ready);
  modport sink   (input valid, event_valid, key_code, stable_row, output ready);
endinterface

### rtl/kmds_ram.sv
// ---------------------------------------------------------------------------
// kmds_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module kmds_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kmds_row_update.sv
// ---------------------------------------------------------------------------
// kmds_row_update
// debounce step for one row and lowest new press encoder
// ---------------------------------------------------------------------------
module kmds_row_update (
  input  logic [kmds_pkg::RowW-1:0] row_i,
  input  logic [kmds_pkg::ColW-1:0] sample_i,
  input  logic                      rcv_ready_i,
  input  logic [kmds_pkg::CntW-1:0] reload_i,
  input  kmds_pkg::row_state_t      cur_i,
  output kmds_pkg::row_state_t      nxt_o,
  output kmds_pkg::row_result_t     res_o
);

  logic [kmds_pkg::ColW-1:0]    pressed;
  logic [kmds_pkg::ColIdxW-1:0] col;

  // lowest set bit of the new presses
  always_comb begin
    col = '0;
    for (int i = kmds_pkg::ColW - 1; i >= 0; i--) begin
      if (pressed[i]) begin
        col = kmds_pkg::ColIdxW'(i);
      end
    end
  end

  always_comb begin
    nxt_o   = cur_i;
    pressed = '0;
    res_o   = '0;
    if (sample_i == cur_i.stable) begin
      nxt_o.cand = sample_i;
    end else if (sample_i != cur_i.cand) begin
      nxt_o.cand  = sample_i;
      nxt_o.count = reload_i;
    end else if (cur_i.count != '0) begin
      nxt_o.count = cur_i.count - 1'b1;
    end else begin
      nxt_o.stable = sample_i;
      pressed      = sample_i & ~cur_i.stable;
    end
    if (pressed != '0 && rcv_ready_i) begin
      res_o.event_valid = 1'b1;
      res_o.key_code    = {row_i, 1'b0, col};
    end
    res_o.stable_row = nxt_o.stable;
  end

endmodule

### rtl/key_matrix_debounce_scanner_unit.sv
// ---------------------------------------------------------------------------
// key_matrix_debounce_scanner_unit
// debounces scanned key matrix rows and reports the lowest new key press
// ---------------------------------------------------------------------------
// path: an accepted word is registered in stage 1, then in the output register
// throughput: one row word per cycle while the output is not stalled, set by the single read and write
//   port of the row state ram (read at accept, modify and write back as the word leaves stage 1)
// reset: row valid flags clear at once so every row reads as all zero state,
//   debounce reload returns to 3, no clearing pass is needed
`include "key_matrix_debounce_scanner_unit_defines.svh"

module key_matrix_debounce_scanner_unit #(
  parameter int KeyRows = kmds_pkg::KeyRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kmds_in_if.sink                   in_i,
  kmds_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [kmds_pkg::CntW-1:0] cfg_wdata_i
);

  localparam int AddrW = (KeyRows > 1) ? $clog2(KeyRows) : 1;
  localparam int StW   = $bits(kmds_pkg::row_state_t);

  // debounce reload register
  logic [kmds_pkg::CntW-1:0] deb_q;

  // per-row valid flags: a row never written reads as zero state
  logic [KeyRows-1:0] row_vld_q;

  // pipeline control
  logic s1_valid_q;
  logic s1_adv;
  logic out_valid_q;
  logic in_fire;

  // stage 1 payload
  logic [kmds_pkg::RowW-1:0] s1_row_q;
  logic [kmds_pkg::ColW-1:0] s1_cols_q;
  logic                      s1_rcv_q;
  logic                      s1_inrange_q;
  logic                      s1_entry_vld_q;

  // forwarding of a write that lands on the row being read
  logic                 byp_hit_q;
  kmds_pkg::row_state_t byp_data_q;

  // ram ports
  logic                 in_range;
  logic [AddrW-1:0]     rd_addr;
  logic [AddrW-1:0]     wr_addr;
  logic                 wr_en;
  logic [StW-1:0]       ram_rdata;
  kmds_pkg::row_state_t cur_state;
  kmds_pkg::row_state_t nxt_state;
  kmds_pkg::row_result_t upd_res;

  // output register
  kmds_pkg::row_result_t out_q;

  // ------------------------------------------------------------------------
  // configuration
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= kmds_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      deb_q <= cfg_wdata_i;
    end
  end

  // ------------------------------------------------------------------------
  // handshake: stage 1 moves on when the output register is free or drains
  // ------------------------------------------------------------------------
  assign s1_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire   = in_i.valid && in_i.ready;

  // rows past the matrix leave the state alone
  assign in_range = {1'b0, in_i.row_index} < (kmds_pkg::RowW + 1)'(KeyRows);
  assign rd_addr  = in_range ? AddrW'(in_i.row_index) : '0;
  assign wr_addr  = AddrW'(s1_row_q);
  assign wr_en    = s1_adv && s1_inrange_q;

  // ------------------------------------------------------------------------
  // row state memory
  // ------------------------------------------------------------------------
  kmds_ram #(
    .Width (StW),
    .Depth (KeyRows)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (nxt_state),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------------
  // stage 1 capture; read data and bypass hold while stalled
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        byp_hit_q  <= wr_en && (wr_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q       <= in_i.row_index;
      s1_cols_q      <= in_i.column_bits;
      s1_rcv_q       <= in_i.receiver_ready;
      s1_inrange_q   <= in_range;
      s1_entry_vld_q <= row_vld_q[rd_addr];
      byp_data_q     <= nxt_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // current row state: forwarded write, stored word, or zero for a fresh row
  always_comb begin
    if (byp_hit_q) begin
      cur_state = byp_data_q;
    end else if (s1_entry_vld_q) begin
      cur_state = kmds_pkg::row_state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  kmds_row_update u_update (
    .row_i       (s1_row_q),
    .sample_i    (s1_cols_q),
    .rcv_ready_i (s1_rcv_q),
    .reload_i    (deb_q),
    .cur_i       (cur_state),
    .nxt_o       (nxt_state),
    .res_o       (upd_res)
  );

  // ------------------------------------------------------------------------
  // output register
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= s1_inrange_q ? upd_res : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_valid = out_q.event_valid;
  assign out_o.key_code    = out_q.key_code;
  assign out_o.stable_row  = out_q.stable_row;

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------
  `KMDS_ASSERT_IMPL(a_event_key_stable, out_valid_q && out_q.event_valid, out_q.stable_row[out_q.key_code[2:0]], "reported key not in stable row")
  `KMDS_ASSERT_IMPL(a_event_row_range, out_valid_q && out_q.event_valid, {1'b0, out_q.key_code[6:4]} < (kmds_pkg::RowW + 1)'(KeyRows), "event from row outside matrix")
  `KMDS_ASSERT_IMPL(a_no_event_zero_code, out_valid_q && !out_q.event_valid, out_q.key_code == '0, "key code set without event")
  `KMDS_ASSERT_IMPL(a_stall_only_full, !in_i.ready, s1_valid_q && out_valid_q && !out_o.ready, "input stalled with free pipeline")
  `KMDS_ASSERT_NEXT(a_write_sets_valid, wr_en, row_vld_q[$past(wr_addr)], "written row not marked valid")

endmodule
